// ----- design/tkh_pkg.sv -----
// ----------------------------------------------------------------------------
// tkh_pkg
// Shared constants, microcode types and the sequencer program for the
// top-k min-heap selector.
// ----------------------------------------------------------------------------
package tkh_pkg;

  localparam int TOP_COUNT_DEF = 10;
  localparam int ValW          = 32;
  localparam int DumpIdxW      = 6;
  localparam int PcW           = 4;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_TAKE,
    ACT_ROOT,
    ACT_BINIT,
    ACT_LOADK,
    ACT_LOADV,
    ACT_SIFTA,
    ACT_SIFTB,
    ACT_KDEC,
    ACT_STATUS,
    ACT_DINIT,
    ACT_DEMIT,
    ACT_DEND
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_REPLACE,
    C_NO_BUILD,
    C_LEAF,
    C_DESCEND,
    C_NO_BUILD_RUN,
    C_K_NONZERO,
    C_OUT_BLOCKED,
    C_NO_EOS,
    C_MORE
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [PcW-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic replace;
    logic no_build;
    logic leaf;
    logic descend;
    logic build_run;
    logic k_nonzero;
    logic out_blocked;
    logic eos;
    logic more;
  } dp_status_t;

  // program steps
  localparam logic [PcW-1:0] StWait   = 4'd0;
  localparam logic [PcW-1:0] StDisp   = 4'd1;
  localparam logic [PcW-1:0] StBinit  = 4'd2;
  localparam logic [PcW-1:0] StLoadK  = 4'd3;
  localparam logic [PcW-1:0] StLoadV  = 4'd4;
  localparam logic [PcW-1:0] StSiftA  = 4'd5;
  localparam logic [PcW-1:0] StSiftB  = 4'd6;
  localparam logic [PcW-1:0] StSEnd   = 4'd7;
  localparam logic [PcW-1:0] StBNext  = 4'd8;
  localparam logic [PcW-1:0] StStatus = 4'd9;
  localparam logic [PcW-1:0] StEosChk = 4'd10;
  localparam logic [PcW-1:0] StDRead  = 4'd11;
  localparam logic [PcW-1:0] StDEmit  = 4'd12;
  localparam logic [PcW-1:0] StDNext  = 4'd13;
  localparam logic [PcW-1:0] StDEnd   = 4'd14;

  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      StWait:   w = '{ACT_TAKE,   C_NO_ACCEPT,    StWait};
      StDisp:   w = '{ACT_ROOT,   C_REPLACE,      StSiftA};
      StBinit:  w = '{ACT_BINIT,  C_NO_BUILD,     StStatus};
      StLoadK:  w = '{ACT_LOADK,  C_NEVER,        StWait};
      StLoadV:  w = '{ACT_LOADV,  C_NEVER,        StWait};
      StSiftA:  w = '{ACT_SIFTA,  C_LEAF,         StSEnd};
      StSiftB:  w = '{ACT_SIFTB,  C_DESCEND,      StSiftA};
      StSEnd:   w = '{ACT_NONE,   C_NO_BUILD_RUN, StStatus};
      StBNext:  w = '{ACT_KDEC,   C_K_NONZERO,    StLoadK};
      StStatus: w = '{ACT_STATUS, C_OUT_BLOCKED,  StStatus};
      StEosChk: w = '{ACT_DINIT,  C_NO_EOS,       StWait};
      StDRead:  w = '{ACT_NONE,   C_NEVER,        StWait};
      StDEmit:  w = '{ACT_DEMIT,  C_OUT_BLOCKED,  StDEmit};
      StDNext:  w = '{ACT_NONE,   C_MORE,         StDRead};
      StDEnd:   w = '{ACT_DEND,   C_ALWAYS,       StWait};
      default:  w = '{ACT_NONE,   C_ALWAYS,       StWait};
    endcase
    return w;
  endfunction

endpackage

// ----- design/tkh_if.sv -----
// ----------------------------------------------------------------------------
// tkh_if
// Sample and result stream interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tkh_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [tkh_pkg::ValW-1:0]   sample_value;
  logic                              start_of_set;
  logic                              end_of_set;

  modport source (output valid, sample_value, start_of_set, end_of_set, input ready);
  modport sink   (input valid, sample_value, start_of_set, end_of_set, output ready);
endinterface

interface tkh_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [tkh_pkg::ValW-1:0]     result_value;
  logic                                filled;
  logic                                is_dump;
  logic        [tkh_pkg::DumpIdxW-1:0] dump_index;
  logic                                last_of_run;

  modport source (output valid, result_value, filled, is_dump, dump_index, last_of_run,
                  input ready);
  modport sink   (input valid, result_value, filled, is_dump, dump_index, last_of_run,
                  output ready);
endinterface

// ----- design/tkh_heap_mem.sv -----
// ----------------------------------------------------------------------------
// tkh_heap_mem
// Heap storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tkh_heap_mem #(
  parameter int Depth = tkh_pkg::TOP_COUNT_DEF,
  parameter int AddrW = 4
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [AddrW-1:0]                waddr_i,
  input  logic signed [tkh_pkg::ValW-1:0] wdata_i,
  input  logic [AddrW-1:0]                raddr_a_i,
  input  logic [AddrW-1:0]                raddr_b_i,
  output logic signed [tkh_pkg::ValW-1:0] rdata_a_o,
  output logic signed [tkh_pkg::ValW-1:0] rdata_b_o
);
  import tkh_pkg::*;

  logic signed [ValW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- design/tkh_sequencer.sv -----
// ----------------------------------------------------------------------------
// tkh_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module tkh_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tkh_pkg::dp_status_t status_i,
  output tkh_pkg::act_e       act_o
);
  import tkh_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         uw;
  logic           jump;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_comb begin
    uw = ucode_rom(pc_q);
    case (uw.cond)
      C_NEVER:        jump = 1'b0;
      C_ALWAYS:       jump = 1'b1;
      C_NO_ACCEPT:    jump = !status_i.in_valid;
      C_REPLACE:      jump = status_i.replace;
      C_NO_BUILD:     jump = status_i.no_build;
      C_LEAF:         jump = status_i.leaf;
      C_DESCEND:      jump = status_i.descend;
      C_NO_BUILD_RUN: jump = !status_i.build_run;
      C_K_NONZERO:    jump = status_i.k_nonzero;
      C_OUT_BLOCKED:  jump = status_i.out_blocked;
      C_NO_EOS:       jump = !status_i.eos;
      C_MORE:         jump = status_i.more;
      default:        jump = 1'b0;
    endcase
    pc_d  = jump ? uw.target : PcW'(pc_q + 1'b1);
    act_o = uw.act;
  end

endmodule

// ----- design/tkh_datapath.sv -----
// ----------------------------------------------------------------------------
// tkh_datapath
// Heap registers, compare/select logic, heap memory and output register,
// driven one action per step by the sequencer.
// ----------------------------------------------------------------------------
module tkh_datapath #(
  parameter int TopCount = tkh_pkg::TOP_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tkh_pkg::act_e                       act_i,
  input  logic                                in_valid_i,
  input  logic signed [tkh_pkg::ValW-1:0]     sample_value_i,
  input  logic                                start_of_set_i,
  input  logic                                end_of_set_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [tkh_pkg::ValW-1:0]     result_value_o,
  output logic                                filled_o,
  output logic                                is_dump_o,
  output logic        [tkh_pkg::DumpIdxW-1:0] dump_index_o,
  output logic                                last_of_run_o,
  output tkh_pkg::dp_status_t                 status_o
);
  import tkh_pkg::*;

  localparam int  AddrW    = (TopCount > 1) ? $clog2(TopCount) : 1;
  localparam int  CntW     = $clog2(TopCount + 1);
  localparam int  IdxW     = AddrW + 2;
  localparam int  BuildTop = (TopCount / 2 > 0) ? TopCount / 2 - 1 : 0;
  localparam bit  NoBuild  = (TopCount / 2 == 0);

  logic [CntW-1:0]        fill_q, fill_d, fill_eff, i_q, i_d;
  logic [AddrW-1:0]       cur_q, cur_d, k_q, k_d;
  logic signed [ValW-1:0] val_q, val_d, root_q, root_d;
  logic                   eos_q, eos_d, repl_q, repl_d, jf_q, jf_d, build_q, build_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [ValW-1:0]  out_value_q, out_value_d;
  logic                    out_filled_q, out_filled_d, out_dump_q, out_dump_d;
  logic                    out_last_q, out_last_d;
  logic [DumpIdxW-1:0]     out_idx_q, out_idx_d;

  logic                   we;
  logic [AddrW-1:0]       waddr, raddr_a, raddr_b;
  logic signed [ValW-1:0] wdata, rdata_a, rdata_b;

  logic [IdxW-1:0]        left_idx, right_idx;
  logic                   leaf, right_ok, pick_right, descend, full, out_blocked;
  logic signed [ValW-1:0] pick_val;
  logic [AddrW-1:0]       pick_idx;

  tkh_heap_mem #(
    .Depth (TopCount),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // child positions and selection
  assign left_idx    = {1'b0, cur_q, 1'b1};
  assign right_idx   = left_idx + 1'b1;
  assign leaf        = left_idx >= IdxW'(TopCount);
  assign right_ok    = right_idx < IdxW'(TopCount);
  assign pick_right  = right_ok && (rdata_a > rdata_b);
  assign pick_val    = pick_right ? rdata_b : rdata_a;
  assign pick_idx    = pick_right ? right_idx[AddrW-1:0] : left_idx[AddrW-1:0];
  assign descend     = val_q > pick_val;
  assign full        = fill_q == CntW'(TopCount);
  assign out_blocked = out_valid_q && !out_ready_i;
  assign fill_eff    = start_of_set_i ? '0 : fill_q;

  always_comb begin
    fill_d  = fill_q;
    i_d     = i_q;
    cur_d   = cur_q;
    k_d     = k_q;
    val_d   = val_q;
    eos_d   = eos_q;
    repl_d  = repl_q;
    jf_d    = jf_q;
    build_d = build_q;
    we      = 1'b0;
    waddr   = cur_q;
    wdata   = val_q;
    raddr_a = i_q[AddrW-1:0];
    raddr_b = i_q[AddrW-1:0];

    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_filled_d = out_filled_q;
    out_dump_d   = out_dump_q;
    out_idx_d    = out_idx_q;
    out_last_d   = out_last_q;

    case (act_i)
      ACT_TAKE: begin
        if (in_valid_i) begin
          val_d   = sample_value_i;
          eos_d   = end_of_set_i;
          build_d = 1'b0;
          if (fill_eff < CntW'(TopCount)) begin
            we     = 1'b1;
            waddr  = fill_eff[AddrW-1:0];
            wdata  = sample_value_i;
            fill_d = fill_eff + 1'b1;
            jf_d   = (fill_eff + 1'b1) == CntW'(TopCount);
            repl_d = 1'b0;
          end else begin
            repl_d = sample_value_i > root_q;
            jf_d   = 1'b0;
          end
        end
      end
      ACT_ROOT: cur_d = '0;
      ACT_BINIT: begin
        build_d = 1'b1;
        k_d     = AddrW'(BuildTop);
      end
      ACT_LOADK: begin
        raddr_a = k_q;
        cur_d   = k_q;
      end
      ACT_LOADV: val_d = rdata_a;
      ACT_SIFTA: begin
        if (leaf) begin
          we = 1'b1;
        end else begin
          raddr_a = left_idx[AddrW-1:0];
          raddr_b = right_ok ? right_idx[AddrW-1:0] : left_idx[AddrW-1:0];
        end
      end
      ACT_SIFTB: begin
        we = 1'b1;
        if (descend) begin
          wdata = pick_val;
          cur_d = pick_idx;
        end
      end
      ACT_KDEC: begin
        if (k_q != '0) begin
          k_d = k_q - 1'b1;
        end
      end
      ACT_STATUS: begin
        if (!out_blocked) begin
          out_valid_d  = 1'b1;
          out_value_d  = full ? root_q : '0;
          out_filled_d = full;
          out_dump_d   = 1'b0;
          out_idx_d    = '0;
          out_last_d   = !eos_q;
        end
      end
      ACT_DINIT: i_d = '0;
      ACT_DEMIT: begin
        if (!out_blocked) begin
          out_valid_d  = 1'b1;
          out_value_d  = rdata_a;
          out_filled_d = full;
          out_dump_d   = 1'b1;
          out_idx_d    = DumpIdxW'(i_q);
          out_last_d   = (i_q + 1'b1) == fill_q;
          i_d          = i_q + 1'b1;
        end
      end
      ACT_DEND: fill_d = '0;
      default: ;
    endcase

    // root mirror
    root_d = (we && waddr == '0) ? wdata : root_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    cur_q        <= cur_d;
    k_q          <= k_d;
    val_q        <= val_d;
    root_q       <= root_d;
    eos_q        <= eos_d;
    repl_q       <= repl_d;
    jf_q         <= jf_d;
    build_q      <= build_d;
    out_value_q  <= out_value_d;
    out_filled_q <= out_filled_d;
    out_dump_q   <= out_dump_d;
    out_idx_q    <= out_idx_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign filled_o       = out_filled_q;
  assign is_dump_o      = out_dump_q;
  assign dump_index_o   = out_idx_q;
  assign last_of_run_o  = out_last_q;

  assign status_o = '{
    in_valid:    in_valid_i,
    replace:     repl_q,
    no_build:    !jf_q || NoBuild,
    leaf:        leaf,
    descend:     descend,
    build_run:   build_q,
    k_nonzero:   k_q != '0,
    out_blocked: out_blocked,
    eos:         eos_q,
    more:        i_q != fill_q
  };

endmodule

// ----- design/top_k_min_heap_select.sv -----
// Each accepted sample yields one registered status beat; a replacing sample is first
// sifted down from the root. The K-th value of a set adds a heap build of K/2 sifts.
// An end of set adds a dump of every entry; the next beat waits until done.
// No new sample beat is taken until the previous one is fully handled, so sifts and
// result stalls lengthen the time between beats.
// Reset clears the fill count and the sequencer; heap contents stay undefined.
// ----------------------------------------------------------------------------
// top_k_min_heap_select
// Keeps the K largest signed values of a set in a min-heap and reports the
// current K-th largest per beat, with a heap dump at end of set.
// ----------------------------------------------------------------------------
module top_k_min_heap_select #(
  parameter int TopCount = tkh_pkg::TOP_COUNT_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tkh_sample_if.sink   sample_i,
  tkh_result_if.source result_o
);
  import tkh_pkg::*;

  act_e       seq_act;
  dp_status_t dp_status;

  tkh_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (dp_status),
    .act_o    (seq_act)
  );

  tkh_datapath #(
    .TopCount (TopCount)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .act_i          (seq_act),
    .in_valid_i     (sample_i.valid),
    .sample_value_i (sample_i.sample_value),
    .start_of_set_i (sample_i.start_of_set),
    .end_of_set_i   (sample_i.end_of_set),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .result_value_o (result_o.result_value),
    .filled_o       (result_o.filled),
    .is_dump_o      (result_o.is_dump),
    .dump_index_o   (result_o.dump_index),
    .last_of_run_o  (result_o.last_of_run),
    .status_o       (dp_status)
  );

  assign sample_i.ready = (seq_act == ACT_TAKE);

  a_accept_leaves_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> seq_act != ACT_TAKE)
    else $error("sequencer still taking input after a beat");

  a_status_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.is_dump |-> result_o.dump_index == '0)
    else $error("status beat with nonzero dump index");

  a_sift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_act == ACT_SIFTB |-> $past(seq_act) == ACT_SIFTA)
    else $error("sift compare step without child read");

endmodule
